// ===== design/tmff_pkg.sv =====
// Shared types, constants and fixed-point helpers for the ten-moment flux block.
// Used by every module of the block; depends on nothing else.
package tmff_pkg;

    localparam int QW       = 32;          // width of one Q16.16 field
    localparam int FRAC     = 16;          // fraction bits
    localparam int NUM_IN   = 10;          // fields in one input request
    localparam int DATA_W   = NUM_IN * QW; // tdata width on both sides
    localparam int DEN_W    = QW - 1;      // magnitude of a valid density
    localparam int DIV_W    = QW + FRAC;   // quotient bits of the divider
    localparam int PROD_W   = 2 * QW;      // full product width
    localparam int TERM_W   = PROD_W - FRAC;

    typedef logic signed [QW-1:0]     q_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TERM_W-1:0] term_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic             bad;
        logic [DEN_W-1:0] den;
        q_t               mx;
        q_t               my;
        q_t               mz;
        q_t               nxx;
        q_t               nxy;
        q_t               nxz;
        q_t               nyy;
        q_t               nyz;
        q_t               nzz;
    } item_t;

    // Clamp a wide signed value to the Q16.16 range.
    function automatic q_t sat32(input prod_t x);
        q_t r;
        if (x > 64'sh0000_0000_7fff_ffff)
            r = 32'sh7fff_ffff;
        else if (x < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[QW-1:0];
        return r;
    endfunction

    // Q16.16 product term: drop the low fraction bits, rounding toward minus infinity.
    function automatic term_t floor16(input prod_t x);
        return x[PROD_W-1:FRAC];
    endfunction

    // Sign-extend a product term back to full width for summing.
    function automatic prod_t ext_term(input term_t t);
        return {{FRAC{t[TERM_W-1]}}, t};
    endfunction

    // Sign-extend a Q16.16 value to full width.
    function automatic prod_t ext_q(input q_t v);
        return {{(PROD_W-QW){v[QW-1]}}, v};
    endfunction

endpackage

// ===== design/tmff_front.sv =====
// Front end: unpacks the input stream and classifies the density of each request.
// Depends on tmff_pkg; feeds tmff_queue.
module tmff_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // density, mom_x, mom_y, mom_z, energy_xx, energy_xy, energy_xz,
    // energy_yy, energy_yz, energy_zz (32 bits each, from the lowest bit up)
    input  logic [tmff_pkg::DATA_W-1:0]   s_axis_tdata,
    output logic                          push_valid,
    input  logic                          push_ready,
    output tmff_pkg::item_t               push_item
);
    import tmff_pkg::*;

    q_t density;

    // Field unpacking.
    assign density = s_axis_tdata[0*QW +: QW];

    // A density of zero or less cannot be divided by.
    always_comb
    begin
        push_item.bad = density[QW-1] | (density == '0);
        push_item.den = density[DEN_W-1:0];
        push_item.mx  = s_axis_tdata[1*QW +: QW];
        push_item.my  = s_axis_tdata[2*QW +: QW];
        push_item.mz  = s_axis_tdata[3*QW +: QW];
        push_item.nxx = s_axis_tdata[4*QW +: QW];
        push_item.nxy = s_axis_tdata[5*QW +: QW];
        push_item.nxz = s_axis_tdata[6*QW +: QW];
        push_item.nyy = s_axis_tdata[7*QW +: QW];
        push_item.nyz = s_axis_tdata[8*QW +: QW];
        push_item.nzz = s_axis_tdata[9*QW +: QW];
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule

// ===== design/tmff_queue.sv =====
// Short queue of classified requests between the front end and the arithmetic back end.
// Depends on tmff_pkg.
module tmff_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tmff_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output tmff_pkg::item_t out_item
);
    import tmff_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid & in_ready;
    assign pop       = out_ready & out_valid;
    assign out_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update with explicit wrap.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// ===== design/tmff_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, Q16.16 result saturated.
// Depends on tmff_pkg; three lanes are used by tmff_back.
module tmff_div (
    input  logic                        clk,
    input  logic                        en,
    input  tmff_pkg::q_t                num,
    input  logic [tmff_pkg::DEN_W-1:0]  den,
    output tmff_pkg::q_t                quo
);
    import tmff_pkg::*;

    localparam int STEPS = DIV_W;

    logic [DEN_W-1:0] rem_reg [STEPS];
    logic [DIV_W-1:0] nq_reg  [STEPS];
    logic [DEN_W-1:0] d_reg   [STEPS];
    logic             neg_reg [STEPS];
    logic [QW-1:0]    mag;
    logic [DIV_W-1:0] q_last;

    // Magnitude of the numerator; the most negative value maps to 2^31.
    assign mag = num[QW-1] ? QW'(-num) : QW'(num);

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic [DEN_W-1:0] rem_in, rem_next;
        logic [DIV_W-1:0] nq_in, nq_next;
        logic [DEN_W-1:0] d_in;
        logic             neg_in;
        logic [QW-1:0]    trial, diff;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign nq_in  = {mag, {FRAC{1'b0}}};
            assign d_in   = den;
            assign neg_in = num[QW-1];
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign d_in   = d_reg[i-1];
            assign neg_in = neg_reg[i-1];
        end

        // Shift in the next numerator bit and subtract when the divisor fits.
        always_comb
        begin
            trial    = {rem_in, nq_in[DIV_W-1]};
            diff     = trial - {1'b0, d_in};
            ge       = (trial >= {1'b0, d_in});
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_next  = {nq_in[DIV_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                nq_reg[i]  <= nq_next;
                d_reg[i]   <= d_in;
                neg_reg[i] <= neg_in;
            end
        end
    end

    // Apply the sign and clamp the truncated quotient.
    assign q_last = nq_reg[STEPS-1];
    always_comb
    begin
        if (neg_reg[STEPS-1])
        begin
            if (q_last > DIV_W'(64'h8000_0000))
                quo = 32'sh8000_0000;
            else
                quo = -q_t'(q_last[QW-1:0]);
        end
        else
        begin
            if (q_last > DIV_W'(64'h7fff_ffff))
                quo = 32'sh7fff_ffff;
            else
                quo = q_t'(q_last[QW-1:0]);
        end
    end

endmodule

// ===== design/tmff_back.sv =====
// Back end: velocity dividers, pressure and flux multiplier stages, output register.
// Depends on tmff_pkg and tmff_div; pulls requests from tmff_queue.
module tmff_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  tmff_pkg::item_t              head_item,
    output logic                         pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // flux_density, flux_mom_x, flux_mom_y, flux_mom_z, flux_xx, flux_xy,
    // flux_xz, flux_yy, flux_yz, flux_zz (32 bits each, from the lowest bit up)
    output logic [tmff_pkg::DATA_W-1:0]  m_axis_tdata,
    // bad_density
    output logic [0:0]                   m_axis_tuser
);
    import tmff_pkg::*;

    localparam int STEPS = DIV_W;

    logic              en;
    logic [STEPS-1:0]  vld_reg;
    item_t             pay_reg [STEPS];
    q_t                ux_div, uy_div, uz_div;

    // Velocity stage.
    logic  vu_reg;
    item_t pu_reg;
    q_t    ux_reg, uy_reg, uz_reg;

    // First product stage.
    logic  va_reg;
    item_t pa_reg;
    q_t    uxa_reg, uya_reg, uza_reg;
    prod_t mux_reg, muy_reg, muz_reg;
    prod_t uxnxx_reg, uynxx_reg, uznxx_reg, uxnyy_reg, uxnyz_reg, uxnzz_reg;

    // Pressure stage.
    logic  vb_reg;
    item_t pb_reg;
    q_t    uxb_reg, uyb_reg, uzb_reg;
    q_t    pxx_reg, pxy_reg, pxz_reg;
    term_t t0b_reg, t1b_reg, t2b_reg, t3b_reg, t4b_reg, t5b_reg;

    // Second product stage.
    logic  vc_reg;
    item_t pc_reg;
    term_t t0c_reg, t1c_reg, t2c_reg, t3c_reg, t4c_reg, t5c_reg;
    prod_t uxpxx_reg, uxpxy_reg, uxpxz_reg, uypxy_reg, uzpxy_reg, uypxz_reg, uzpxz_reg;

    // Output register.
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_bad_reg;

    // Everything advances together unless a finished result is held.
    assign en  = !out_valid_reg || m_axis_tready;
    assign pop = en & head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            vu_reg        <= 1'b0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[STEPS-2:0], head_valid};
            vu_reg        <= vld_reg[STEPS-1];
            va_reg        <= vu_reg;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            out_valid_reg <= vc_reg;
        end
    end

    // Request fields travel beside the divider lanes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0] <= head_item;
            for (int i = 1; i < STEPS; i++)
                pay_reg[i] <= pay_reg[i-1];
        end
    end

    tmff_div u_div_x (.clk(clk), .en(en), .num(head_item.mx), .den(head_item.den),
                      .quo(ux_div));
    tmff_div u_div_y (.clk(clk), .en(en), .num(head_item.my), .den(head_item.den),
                      .quo(uy_div));
    tmff_div u_div_z (.clk(clk), .en(en), .num(head_item.mz), .den(head_item.den),
                      .quo(uz_div));

    // Arithmetic stages: velocities, products, pressures, pressure products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg <= pay_reg[STEPS-1];
            ux_reg <= ux_div;
            uy_reg <= uy_div;
            uz_reg <= uz_div;

            pa_reg    <= pu_reg;
            uxa_reg   <= ux_reg;
            uya_reg   <= uy_reg;
            uza_reg   <= uz_reg;
            mux_reg   <= pu_reg.mx * ux_reg;
            muy_reg   <= pu_reg.mx * uy_reg;
            muz_reg   <= pu_reg.mx * uz_reg;
            uxnxx_reg <= ux_reg * pu_reg.nxx;
            uynxx_reg <= uy_reg * pu_reg.nxx;
            uznxx_reg <= uz_reg * pu_reg.nxx;
            uxnyy_reg <= ux_reg * pu_reg.nyy;
            uxnyz_reg <= ux_reg * pu_reg.nyz;
            uxnzz_reg <= ux_reg * pu_reg.nzz;

            pb_reg  <= pa_reg;
            uxb_reg <= uxa_reg;
            uyb_reg <= uya_reg;
            uzb_reg <= uza_reg;
            pxx_reg <= sat32(ext_q(pa_reg.nxx) - ext_term(floor16(mux_reg)));
            pxy_reg <= sat32(ext_q(pa_reg.nxy) - ext_term(floor16(muy_reg)));
            pxz_reg <= sat32(ext_q(pa_reg.nxz) - ext_term(floor16(muz_reg)));
            t0b_reg <= floor16(uxnxx_reg);
            t1b_reg <= floor16(uynxx_reg);
            t2b_reg <= floor16(uznxx_reg);
            t3b_reg <= floor16(uxnyy_reg);
            t4b_reg <= floor16(uxnyz_reg);
            t5b_reg <= floor16(uxnzz_reg);

            pc_reg    <= pb_reg;
            t0c_reg   <= t0b_reg;
            t1c_reg   <= t1b_reg;
            t2c_reg   <= t2b_reg;
            t3c_reg   <= t3b_reg;
            t4c_reg   <= t4b_reg;
            t5c_reg   <= t5b_reg;
            uxpxx_reg <= uxb_reg * pxx_reg;
            uxpxy_reg <= uxb_reg * pxy_reg;
            uxpxz_reg <= uxb_reg * pxz_reg;
            uypxy_reg <= uyb_reg * pxy_reg;
            uzpxy_reg <= uzb_reg * pxy_reg;
            uypxz_reg <= uyb_reg * pxz_reg;
            uzpxz_reg <= uzb_reg * pxz_reg;
        end
    end

    // Flux sums; a doubled term is the floored term shifted left once.
    always_comb
    begin
        out_data_next = '0;
        if (!pc_reg.bad)
        begin
            out_data_next[0*QW +: QW] = pc_reg.mx;
            out_data_next[1*QW +: QW] = pc_reg.nxx;
            out_data_next[2*QW +: QW] = pc_reg.nxy;
            out_data_next[3*QW +: QW] = pc_reg.nxz;
            out_data_next[4*QW +: QW] = sat32(ext_term(t0c_reg)
                                        + (ext_term(floor16(uxpxx_reg)) <<< 1));
            out_data_next[5*QW +: QW] = sat32(ext_term(t1c_reg)
                                        + (ext_term(floor16(uxpxy_reg)) <<< 1));
            out_data_next[6*QW +: QW] = sat32(ext_term(t2c_reg)
                                        + (ext_term(floor16(uxpxz_reg)) <<< 1));
            out_data_next[7*QW +: QW] = sat32(ext_term(t3c_reg)
                                        + (ext_term(floor16(uypxy_reg)) <<< 1));
            out_data_next[8*QW +: QW] = sat32(ext_term(t4c_reg)
                                        + ext_term(floor16(uzpxy_reg))
                                        + ext_term(floor16(uypxz_reg)));
            out_data_next[9*QW +: QW] = sat32(ext_term(t5c_reg)
                                        + (ext_term(floor16(uzpxz_reg)) <<< 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_bad_reg  <= pc_reg.bad;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_bad_reg;

endmodule

// ===== design/ten_moment_fluid_flux.sv =====
// Top level of the ten-moment fluid flux block: front end, request queue, back end.
// Depends on tmff_pkg, tmff_front, tmff_queue and tmff_back.
//
// Each request carries one species' ten conserved moments at one point and
// yields one result with the ten x-direction fluxes in signed Q16.16, plus a
// bad-density flag (density zero or negative; all fluxes are then zero).
// The block accepts one request per clock and delivers one result per clock
// while the output side keeps taking them. A request is registered in the
// input queue, then passes through the three parallel velocity dividers,
// which retire one quotient bit per stage, then four arithmetic stages and
// the output register. A held result stalls the back end; the queue keeps
// taking requests until it is full.
module ten_moment_fluid_flux #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // density, mom_x, mom_y, mom_z, energy_xx, energy_xy, energy_xz,
    // energy_yy, energy_yz, energy_zz (32 bits each, from the lowest bit up)
    input  logic [tmff_pkg::DATA_W-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // flux_density, flux_mom_x, flux_mom_y, flux_mom_z, flux_xx, flux_xy,
    // flux_xz, flux_yy, flux_yz, flux_zz (32 bits each, from the lowest bit up)
    output logic [tmff_pkg::DATA_W-1:0] m_axis_tdata,
    // bad_density
    output logic [0:0]                  m_axis_tuser
);
    import tmff_pkg::*;

    logic  push_valid, push_ready;
    item_t push_item;
    logic  head_valid, pop;
    item_t head_item;

    tmff_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    tmff_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (head_valid),
        .out_ready (pop),
        .out_item  (head_item)
    );

    tmff_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
